>>> rtl/core/pgbs_pkg.sv
// ----------------------------------------------------------------------------
// pgbs_pkg
// Shared types and constants of the point grid binning statistics core.
// ----------------------------------------------------------------------------
package pgbs_pkg;

	// configuration register indexes
	localparam logic [7:0] REG_LON_MIN   = 8'd0;
	localparam logic [7:0] REG_LON_MAX   = 8'd1;
	localparam logic [7:0] REG_LAT_MIN   = 8'd2;
	localparam logic [7:0] REG_LAT_MAX   = 8'd3;
	localparam logic [7:0] REG_GRID_W    = 8'd4;
	localparam logic [7:0] REG_GRID_H    = 8'd5;
	localparam logic [7:0] REG_BANDS     = 8'd6;
	localparam logic [7:0] REG_STATS_EN  = 8'd7;

	localparam logic KIND_SPLAT = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	localparam int COORD_W = 29;

	// divider handshake back to the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

	// one grid cell as kept in the cell store
	typedef struct packed {
		logic [15:0] cnt;
		logic [31:0] sum;
		logic [15:0] min;
		logic [15:0] max;
	} cell_entry_t;

	localparam cell_entry_t CELL_INIT = '{cnt: 16'd0, sum: 32'd0, min: 16'hFFFF, max: 16'd0};

	typedef struct packed {
		logic        kind;
		logic        in_grid;
		logic [15:0] hit;
		logic [15:0] count;
		logic [15:0] average;
		logic [15:0] minimum;
		logic [15:0] maximum;
		logic        occupied;
	} result_t;

	typedef enum logic [16:0] {
		ST_CLEAR   = 17'b00000000000000001,
		ST_IDLE    = 17'b00000000000000010,
		ST_MEAN    = 17'b00000000000000100,
		ST_LON_MUL = 17'b00000000000001000,
		ST_LON_GO  = 17'b00000000000010000,
		ST_LON_DIV = 17'b00000000000100000,
		ST_LAT_MUL = 17'b00000000001000000,
		ST_LAT_GO  = 17'b00000000010000000,
		ST_LAT_DIV = 17'b00000000100000000,
		ST_CELL    = 17'b00000001000000000,
		ST_UPD_RD  = 17'b00000010000000000,
		ST_UPD_WR  = 17'b00000100000000000,
		ST_RD_ADDR = 17'b00001000000000000,
		ST_RD_CHK  = 17'b00010000000000000,
		ST_AVG     = 17'b00100000000000000,
		ST_RES     = 17'b01000000000000000,
		ST_SPARE   = 17'b10000000000000000
	} state_t;

endpackage

>>> rtl/core/pgbs_ram.sv
// ----------------------------------------------------------------------------
// pgbs_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module pgbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/core/pgbs_div.sv
// ----------------------------------------------------------------------------
// pgbs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pgbs_div import pgbs_pkg::*; #(
	parameter int DVW = 37,
	parameter int VW  = 29
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [DVW-1:0] dividend,
	input  logic [VW-1:0]  divisor,
	output div_status_t    stat,
	output logic [DVW-1:0] quotient
);

	localparam int CW = $clog2(DVW + 1);

	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [VW:0]    rem_q;
	logic [DVW-1:0] quo_q;
	logic [VW-1:0]  dsr_q;
	logic [VW:0]    rem_sh;
	logic           fits;

	assign rem_sh = {rem_q[VW-1:0], quo_q[DVW-1]};
	assign fits   = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DVW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
			quo_q <= {quo_q[DVW-2:0], fits};
		end
	end

	assign stat     = '{busy: busy_q, done: done_q};
	assign quotient = quo_q;

endmodule

>>> rtl/core/point_grid_binning_stats_core.sv
// ----------------------------------------------------------------------------
// point_grid_binning_stats_core
// Bins points into a configurable grid and keeps per-cell count, sum, min, max.
// ----------------------------------------------------------------------------
// Band samples stream in on the slave side; the one with tlast closes the
// point, whose mean is splatted into the grid, and one acknowledge transfer
// leaves on the master side. A read command returns one cell's statistics.
// A sample that is not the last is added to the band sum and the next item
// can be taken at once. The last sample runs three passes through the shared
// bit-serial divider (band mean, column, row), each giving a DVW-bit quotient
// (DVW is 37 at the default grid); an empty axis range stops after the mean
// pass, and a point off the grid skips the cell update states. A read runs a
// further divider pass for the average only when the cell is occupied. A held
// result stalls the sequencer in its result state. After reset a clearing
// pass writes every one of MAX_WIDTH*MAX_HEIGHT cells before the first item
// is taken; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module point_grid_binning_stats_core import pgbs_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// longitude[28:0], latitude[57:29], band_value[73:58], cell_index[89:74]
	input  logic [95:0] s_axis_tdata,
	input  logic        s_axis_tlast,   // last_band
	input  logic        s_axis_tuser,   // cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// inside_res[0], hit_cell[16:1], count[32:17], average[48:33],
	// minimum[64:49], maximum[80:65], occupied[81]
	output logic [87:0] m_axis_tdata,
	output logic        m_axis_tuser,   // result_kind
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [28:0] cfg_data
);

	localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(CELLS);
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int AXW   = (XW > YW) ? XW : YW;
	// dividend must hold (dim-1)*|offset| and a 32-bit cell sum
	localparam int DVW   = (AXW + COORD_W > 32) ? AXW + COORD_W : 32;
	localparam int VW    = COORD_W;

	// ---------------- configuration ----------------
	logic signed [28:0] lon_min_q, lon_max_q, lat_min_q, lat_max_q;
	logic [8:0]         grid_w_q, grid_h_q, bands_q;
	logic               stats_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lon_min_q <= '0;
			lon_max_q <= 29'sd1048576;
			lat_min_q <= '0;
			lat_max_q <= 29'sd1048576;
			grid_w_q  <= 9'd256;
			grid_h_q  <= 9'd256;
			bands_q   <= 9'd1;
			stats_q   <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LON_MIN:  lon_min_q <= cfg_data;
				REG_LON_MAX:  lon_max_q <= cfg_data;
				REG_LAT_MIN:  lat_min_q <= cfg_data;
				REG_LAT_MAX:  lat_max_q <= cfg_data;
				REG_GRID_W:   grid_w_q  <= cfg_data[8:0];
				REG_GRID_H:   grid_h_q  <= cfg_data[8:0];
				REG_BANDS:    bands_q   <= cfg_data[8:0];
				REG_STATS_EN: stats_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// clamped grid size and divisor
	logic [WW-1:0] w_c;
	logic [HW-1:0] h_c;
	logic [8:0]    bands_c;

	always_comb begin
		if (grid_w_q == 9'd0) begin
			w_c = WW'(1);
		end else if (32'(grid_w_q) > MAX_WIDTH) begin
			w_c = WW'(MAX_WIDTH);
		end else begin
			w_c = WW'(grid_w_q);
		end
		if (grid_h_q == 9'd0) begin
			h_c = HW'(1);
		end else if (32'(grid_h_q) > MAX_HEIGHT) begin
			h_c = HW'(MAX_HEIGHT);
		end else begin
			h_c = HW'(grid_h_q);
		end
		bands_c = (bands_q == 9'd0) ? 9'd1 : bands_q;
	end

	// ---------------- input fields ----------------
	logic signed [28:0] in_lon, in_lat;
	logic [15:0]        in_band, in_idx;
	logic               s_fire;

	assign in_lon  = s_axis_tdata[28:0];
	assign in_lat  = s_axis_tdata[57:29];
	assign in_band = s_axis_tdata[73:58];
	assign in_idx  = s_axis_tdata[89:74];

	// ---------------- sequencer state ----------------
	state_t             state_q;
	logic [AW-1:0]      clr_addr_q;
	logic [23:0]        bsum_q;
	logic signed [28:0] lon_q, lat_q;
	logic [AW-1:0]      idx_q;
	logic               idx_ok_q;
	logic [15:0]        mean_q;
	logic [DVW-1:0]     prod_q;
	logic               neg_q;
	logic               col_ok_q;
	logic [XW-1:0]      col_q;
	logic [YW-1:0]      row_q;
	logic [AW-1:0]      cell_q;
	cell_entry_t        ent_q;
	result_t            res_q;
	result_t            out_q;
	logic               out_valid_q;

	// band sum with saturation at 2^24-1
	logic [24:0] bsum_add;
	logic [23:0] bsum_new;

	assign bsum_add = {1'b0, bsum_q} + 25'(in_band);
	assign bsum_new = bsum_add[24] ? 24'hFFFFFF : bsum_add[23:0];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	// ---------------- axis offsets ----------------
	logic signed [29:0] lon_d, lat_d, lon_span, lat_span;
	logic [28:0]        lon_mag, lat_mag;
	logic               ranges_ok;

	assign lon_d    = 30'(lon_q) - 30'(lon_min_q);
	assign lat_d    = 30'(lat_q) - 30'(lat_min_q);
	assign lon_span = 30'(lon_max_q) - 30'(lon_min_q);
	assign lat_span = 30'(lat_max_q) - 30'(lat_min_q);
	assign lon_mag  = lon_d[29] ? 29'(-lon_d) : lon_d[28:0];
	assign lat_mag  = lat_d[29] ? 29'(-lat_d) : lat_d[28:0];
	assign ranges_ok = (lon_max_q > lon_min_q) && (lat_max_q > lat_min_q);

	// ---------------- shared divider ----------------
	div_status_t    div_stat;
	logic           div_start;
	logic [DVW-1:0] div_dvd;
	logic [VW-1:0]  div_dvs;
	logic [DVW-1:0] div_quo;

	cell_entry_t    rd_ent;
	logic           rd_hit;

	assign rd_hit = idx_ok_q && (rd_ent.cnt != 16'd0);

	always_comb begin
		div_start = 1'b0;
		div_dvd   = DVW'(bsum_new);
		div_dvs   = VW'(bands_c);
		unique case (state_q)
			ST_IDLE: begin
				div_start = s_fire && (s_axis_tuser == CMD_SAMPLE) && s_axis_tlast;
			end
			ST_LON_GO: begin
				div_start = 1'b1;
				div_dvd   = prod_q;
				div_dvs   = lon_span[28:0];
			end
			ST_LAT_GO: begin
				div_start = 1'b1;
				div_dvd   = prod_q;
				div_dvs   = lat_span[28:0];
			end
			ST_RD_CHK: begin
				div_start = rd_hit;
				div_dvd   = DVW'(rd_ent.sum);
				div_dvs   = VW'(rd_ent.cnt);
			end
			default: ;
		endcase
	end

	pgbs_div #(.DVW(DVW), .VW(VW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// ---------------- cell store ----------------
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	cell_entry_t   ram_wdata, upd_ent;

	always_comb begin
		upd_ent = rd_ent;
		if (rd_ent.cnt != 16'hFFFF) begin
			upd_ent.cnt = rd_ent.cnt + 16'd1;
			if (stats_q) begin
				upd_ent.sum = rd_ent.sum + 32'(mean_q);
			end
		end
		if (stats_q) begin
			if (mean_q < rd_ent.min) begin
				upd_ent.min = mean_q;
			end
			if (mean_q > rd_ent.max) begin
				upd_ent.max = mean_q;
			end
		end
	end

	assign ram_we    = (state_q == ST_CLEAR) || (state_q == ST_UPD_WR);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_addr_q : cell_q;
	assign ram_wdata = (state_q == ST_CLEAR) ? CELL_INIT : upd_ent;
	assign ram_raddr = (state_q == ST_RD_ADDR) ? idx_q : cell_q;

	pgbs_ram #(.WIDTH($bits(cell_entry_t)), .DEPTH(CELLS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd_ent)
	);

	// ---------------- axis results ----------------
	// a negative offset truncates toward zero: only a zero quotient stays in
	logic         col_ok_c, row_ok_c;
	logic [31:0]  cell_c;

	assign col_ok_c = neg_q ? (div_quo == '0) : (div_quo < DVW'(w_c));
	assign row_ok_c = neg_q ? (div_quo == '0) : (div_quo < DVW'(h_c));
	assign cell_c   = 32'(row_q) * 32'(w_c) + 32'(col_q);

	// ---------------- sequencer ----------------
	// result register loads when it is empty or its transfer happens now
	logic out_load;

	assign out_load = (state_q == ST_RES) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			bsum_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_fire) begin
						if (s_axis_tuser == CMD_READ) begin
							state_q <= ST_RD_ADDR;
						end else if (s_axis_tlast) begin
							bsum_q  <= '0;
							state_q <= ST_MEAN;
						end else begin
							bsum_q <= bsum_new;
						end
					end
				end
				ST_MEAN:    if (div_stat.done) state_q <= ranges_ok ? ST_LON_MUL : ST_RES;
				ST_LON_MUL: state_q <= ST_LON_GO;
				ST_LON_GO:  state_q <= ST_LON_DIV;
				ST_LON_DIV: if (div_stat.done) state_q <= ST_LAT_MUL;
				ST_LAT_MUL: state_q <= ST_LAT_GO;
				ST_LAT_GO:  state_q <= ST_LAT_DIV;
				ST_LAT_DIV: begin
					if (div_stat.done) begin
						state_q <= (col_ok_q && row_ok_c) ? ST_CELL : ST_RES;
					end
				end
				ST_CELL:    state_q <= ST_UPD_RD;
				ST_UPD_RD:  state_q <= ST_UPD_WR;
				ST_UPD_WR:  state_q <= ST_RES;
				ST_RD_ADDR: state_q <= ST_RD_CHK;
				ST_RD_CHK:  state_q <= rd_hit ? ST_AVG : ST_RES;
				ST_AVG:     if (div_stat.done) state_q <= ST_RES;
				ST_RES: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default:    state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res_q;
		end
		unique case (state_q)
			ST_IDLE: begin
				lon_q    <= in_lon;
				lat_q    <= in_lat;
				idx_q    <= AW'(in_idx);
				idx_ok_q <= 32'(in_idx) < CELLS;
				res_q    <= '{kind: KIND_SPLAT, in_grid: 1'b0, hit: 16'd0, count: 16'd0,
					average: 16'd0, minimum: 16'd0, maximum: 16'd0, occupied: 1'b0};
			end
			ST_MEAN: begin
				mean_q <= (div_quo > DVW'(16'hFFFF)) ? 16'hFFFF : div_quo[15:0];
			end
			ST_LON_MUL: begin
				prod_q <= (DVW'(w_c) - DVW'(1)) * DVW'(lon_mag);
				neg_q  <= lon_d[29];
			end
			ST_LON_DIV: begin
				col_ok_q <= col_ok_c;
				col_q    <= neg_q ? '0 : XW'(div_quo);
			end
			ST_LAT_MUL: begin
				prod_q <= (DVW'(h_c) - DVW'(1)) * DVW'(lat_mag);
				neg_q  <= lat_d[29];
			end
			ST_LAT_DIV: begin
				row_q <= YW'(DVW'(h_c) - DVW'(1) - (neg_q ? '0 : div_quo));
			end
			ST_CELL: begin
				cell_q <= AW'(cell_c);
			end
			ST_UPD_WR: begin
				res_q.in_grid <= 1'b1;
				res_q.hit     <= 16'(cell_q);
			end
			ST_RD_CHK: begin
				ent_q         <= rd_ent;
				res_q.kind    <= KIND_READ;
				res_q.count   <= idx_ok_q ? rd_ent.cnt : 16'd0;
				res_q.minimum <= idx_ok_q ? rd_ent.min : 16'hFFFF;
				res_q.maximum <= idx_ok_q ? rd_ent.max : 16'd0;
				res_q.occupied <= rd_hit;
			end
			ST_AVG: begin
				if (div_stat.done && ent_q.cnt != 16'd0) begin
					res_q.average <= div_quo[15:0];
				end
			end
			default: ;
		endcase
	end

	// ---------------- master side ----------------
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tdata  = {6'd0, out_q.occupied, out_q.maximum, out_q.minimum,
		out_q.average, out_q.count, out_q.hit, out_q.in_grid};

	// ---------------- checks ----------------
	// only a non-final band sample lets the block take the next item at once
	a_busy_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && (s_axis_tuser == CMD_READ || s_axis_tlast)) |=> !s_axis_tready)
		else $error("item taken while a previous one is in work");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider restarted while busy");

	// an empty cell reads back a zero average
	a_empty_avg: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == KIND_READ && !m_axis_tdata[81])
		|-> (m_axis_tdata[48:33] == 16'd0))
		else $error("average reported for an empty cell");

	// a splat acknowledge never carries read statistics
	a_splat_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == KIND_SPLAT) |-> (m_axis_tdata[81:17] == '0))
		else $error("read fields set on a splat acknowledge");

endmodule
